FILE: rtl/core/lpfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpfd_pkg: shared types and constants of the frame deframer
// Status codes, deframer state record and per-byte result record.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  // header layout: 16-bit type then 32-bit length, little endian
  localparam int unsigned HeaderBytes  = 6;
  localparam int unsigned HdrCntW      = 3;
  localparam int unsigned HdrStoreW    = 8 * (HeaderBytes - 1);
  localparam logic [HdrCntW-1:0] HdrLastIdx = HdrCntW'(HeaderBytes - 1);

  // register reset value
  localparam logic [15:0] MaxPayloadRst = 16'd32768;

  // per-byte status codes
  typedef enum logic [2:0] {
    StHeader   = 3'd0,
    StPayload  = 3'd1,
    StEmpty    = 3'd2,
    StOversize = 3'd3,
    StDiscard  = 3'd4
  } status_e;

  // deframer state carried from byte to byte
  typedef struct packed {
    logic                 in_payload;
    logic                 failed;
    logic [HdrStoreW-1:0] header_store;
    logic [HdrCntW-1:0]   header_count;
    logic [15:0]          current_type;
    logic [15:0]          current_length;
    logic [15:0]          received_count;
  } state_t;

  // one result item
  typedef struct packed {
    status_e     status;
    logic [7:0]  data_byte;
    logic [15:0] frame_type;
    logic [15:0] frame_length;
    logic        frame_end;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/lpfd_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpfd_step: per-byte deframer logic
// Computes the next deframer state and the result for one received byte.
// ----------------------------------------------------------------------------
module lpfd_step import lpfd_pkg::*; (
  input  state_t      state_i,
  input  logic [7:0]  in_byte_i,
  input  logic [15:0] max_payload_i,
  output state_t      state_o,
  output result_t     result_o
);

  logic [15:0] rcv_inc;
  logic [31:0] hdr_len;
  logic [15:0] hdr_type;
  logic [15:0] len_sat;

  assign rcv_inc  = state_i.received_count + 16'd1;
  assign hdr_type = state_i.header_store[15:0];
  assign hdr_len  = {in_byte_i, state_i.header_store[HdrStoreW-1:16]};
  assign len_sat  = (hdr_len[31:16] != 16'd0) ? 16'hFFFF : hdr_len[15:0];

  always_comb begin
    state_o               = state_i;
    result_o.status       = StHeader;
    result_o.data_byte    = in_byte_i;
    result_o.frame_type   = state_i.current_type;
    result_o.frame_length = state_i.current_length;
    result_o.frame_end    = 1'b0;

    if (state_i.failed) begin
      // sticky error: discard everything
      result_o.status = StDiscard;
    end else if (state_i.in_payload) begin
      // payload byte, count and check for frame end
      result_o.status         = StPayload;
      state_o.received_count  = rcv_inc;
      if (rcv_inc >= state_i.current_length) begin
        state_o.in_payload   = 1'b0;
        state_o.header_count = '0;
        state_o.header_store = '0;
        result_o.frame_end   = 1'b1;
      end
    end else if (state_i.header_count < HdrLastIdx) begin
      // collect a header byte into its lane
      result_o.frame_type   = 16'd0;
      result_o.frame_length = 16'd0;
      for (int k = 0; k < HeaderBytes - 1; k++) begin
        if (state_i.header_count == HdrCntW'(k)) begin
          state_o.header_store[8*k +: 8] = state_i.header_store[8*k +: 8] | in_byte_i;
        end
      end
      state_o.header_count = state_i.header_count + 1'b1;
    end else begin
      // last header byte: decode and check the length
      state_o.header_count   = '0;
      state_o.header_store   = '0;
      state_o.received_count = '0;
      state_o.current_type   = hdr_type;
      state_o.current_length = len_sat;
      result_o.frame_type    = hdr_type;
      result_o.frame_length  = len_sat;
      if (hdr_len > {16'd0, max_payload_i}) begin
        state_o.failed  = 1'b1;
        result_o.status = StOversize;
      end else if (hdr_len == 32'd0) begin
        result_o.status    = StEmpty;
        result_o.frame_end = 1'b1;
      end else begin
        state_o.in_payload = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/length_prefixed_frame_deframer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_core: type-length-value byte deframer
// Splits a byte stream into frames with a six-byte little-endian header
// (16-bit type, 32-bit length) and flags oversize frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one stream byte per transfer (in_valid_i / in_stall_o).
//   Output channel: exactly one result per input byte (out_valid_o /
//   out_stall_i) with status, byte, frame type, frame length and end mark.
//   A byte's result appears in the output register in the cycle after the
//   byte is taken. Throughput is one byte per cycle while the receiver does
//   not stall; the state update is a single pass of counter, compare and
//   header assembly logic between the state register and result register.
//   When the receiver stalls, the result register holds its item and the
//   input stalls only while that item is still waiting; a byte is taken in
//   the same cycle the waiting result is transferred.
//   Reset clears the deframer state and the sticky error, empties the
//   result register and sets max_payload to 32768. After an oversize frame
//   every byte is reported as discarded until the next reset.
//   max_payload_we_i writes the limit; write it only while idle.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_core import lpfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        max_payload_we_i,
  input  logic [15:0] max_payload_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] frame_type_o,
  output logic [15:0] frame_length_o,
  output logic        frame_end_o
);

  logic [15:0] max_payload_q;
  state_t      state_q, state_d;
  result_t     res_d, res_q;
  logic        out_valid_q;
  logic        in_xfer;

  // accept a byte unless a waiting result is stalled
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadRst;
    end else if (max_payload_we_i) begin
      max_payload_q <= max_payload_i;
    end
  end

  // per-byte logic
  lpfd_step u_step (
    .state_i      (state_q),
    .in_byte_i    (in_byte_i),
    .max_payload_i(max_payload_q),
    .state_o      (state_d),
    .result_o     (res_d)
  );

  // deframer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign data_byte_o    = res_q.data_byte;
  assign frame_type_o   = res_q.frame_type;
  assign frame_length_o = res_q.frame_length;
  assign frame_end_o    = res_q.frame_end;

endmodule
`default_nettype wire
